// ===== hw/rtl/gamepad_dpad_ramp_event_encoder_top_defines.svh =====
// Assertion macros for the encoder's RTL, included by gdpre_emit.
// Expects clk and arst_n in the scope of every use.
`ifndef GAMEPAD_DPAD_RAMP_EVENT_ENCODER_TOP_DEFINES_SVH
`define GAMEPAD_DPAD_RAMP_EVENT_ENCODER_TOP_DEFINES_SVH

// same-cycle implication, idle during reset
`define GDPRE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gdpre assertion failed");

// next-cycle implication, idle during reset
`define GDPRE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gdpre assertion failed");

`endif

// ===== hw/rtl/gdpre_pkg.sv =====
// Shared types and constants for the D-pad ramp event encoder.
// No dependencies; the other RTL modules refer to it by scoped names.
`default_nettype none

package gdpre_pkg;

	localparam int unsigned NumButtons = 18;
	localparam int unsigned BtnIdxW    = $clog2(NumButtons);
	localparam int unsigned RampW      = 15;
	localparam int unsigned RampMax    = 32767;
	localparam int unsigned AddrW      = 3;
	localparam int unsigned DataW      = 32;

	localparam logic [RampW-1:0] UpStepReset   = 15'd546;
	localparam logic [RampW-1:0] DownStepReset = 15'd273;

	// register index, taken from paddr[2]
	localparam logic RegUpStep   = 1'b0;
	localparam logic RegDownStep = 1'b1;

	typedef enum logic [1:0] {
		KIND_BUTTON = 2'd0,
		KIND_AXIS   = 2'd1,
		KIND_MARK   = 2'd2
	} kind_t;

	localparam logic [4:0] AxisHoriz = 5'd0;
	localparam logic [4:0] AxisVert  = 5'd1;

	typedef struct packed {
		logic [17:0] button_bits;
		logic        dir_left;
		logic        dir_right;
		logic        dir_up;
		logic        dir_down;
	} in_t;

	typedef struct packed {
		kind_t              event_kind;
		logic [4:0]         event_index;
		logic signed [15:0] event_value;
		logic               is_last;
	} out_t;

	typedef struct packed {
		logic [RampW-1:0] up_step;
		logic [RampW-1:0] down_step;
	} cfg_t;

	// everything one poll sample has to emit
	typedef struct packed {
		logic [NumButtons-1:0] chg;
		logic [NumButtons-1:0] buttons;
		logic                  send_h;
		logic signed [15:0]    h_val;
		logic                  send_v;
		logic signed [15:0]    v_val;
	} batch_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gdpre_regs.sv =====
// APB-style configuration registers: ramp up and ramp down steps.
// Uses gdpre_pkg.
`default_nettype none

module gdpre_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gdpre_pkg::AddrW-1:0]  paddr,
	input  wire logic [gdpre_pkg::DataW-1:0]  pwdata,
	output logic      [gdpre_pkg::DataW-1:0]  prdata,
	output logic                              pready,
	output gdpre_pkg::cfg_t                   cfg
);

	logic            wr_en;
	logic            reg_idx;
	gdpre_pkg::cfg_t cfg_q;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.up_step   <= gdpre_pkg::UpStepReset;
			cfg_q.down_step <= gdpre_pkg::DownStepReset;
		end else if (wr_en) begin
			case (reg_idx)
				gdpre_pkg::RegUpStep:   cfg_q.up_step   <= pwdata[gdpre_pkg::RampW-1:0];
				gdpre_pkg::RegDownStep: cfg_q.down_step <= pwdata[gdpre_pkg::RampW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			gdpre_pkg::RegUpStep:
				prdata = {{(gdpre_pkg::DataW-gdpre_pkg::RampW){1'b0}}, cfg_q.up_step};
			gdpre_pkg::RegDownStep:
				prdata = {{(gdpre_pkg::DataW-gdpre_pkg::RampW){1'b0}}, cfg_q.down_step};
			default:
				prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gdpre_core.sv =====
// Poll-sample state: ramp, previous sample, last sent axis values.
// Builds the batch of events for each accepted sample. Uses gdpre_pkg.
`default_nettype none

module gdpre_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gdpre_pkg::in_t in_data,
	input  wire logic           accept,
	input  wire gdpre_pkg::cfg_t cfg,
	output gdpre_pkg::batch_t   batch,
	output logic                emits
);

	logic [gdpre_pkg::NumButtons-1:0] prev_buttons_q;
	logic [3:0]                       prev_dirs_q;
	logic [gdpre_pkg::RampW-1:0]      ramp_q;
	logic signed [15:0]               last_h_q;
	logic signed [15:0]               last_v_q;
	logic                             sent_once_q;

	logic [gdpre_pkg::NumButtons-1:0] buttons;
	logic [3:0]                       dirs;
	logic                             held;
	logic [gdpre_pkg::RampW:0]        ramp_sum;
	logic [gdpre_pkg::RampW-1:0]      ramp_next;
	logic signed [15:0]               ramp_s;
	logic signed [15:0]               horiz;
	logic signed [15:0]               vert;

	assign buttons = in_data.button_bits[gdpre_pkg::NumButtons-1:0];
	assign dirs    = {in_data.dir_down, in_data.dir_up, in_data.dir_right, in_data.dir_left};
	assign held    = |dirs;

	always_comb begin
		ramp_sum = {1'b0, ramp_q} + {1'b0, cfg.up_step};
		if (held) begin
			if (ramp_sum > (gdpre_pkg::RampW+1)'(gdpre_pkg::RampMax))
				ramp_next = gdpre_pkg::RampW'(gdpre_pkg::RampMax);
			else
				ramp_next = ramp_sum[gdpre_pkg::RampW-1:0];
		end else if (cfg.down_step > ramp_q) begin
			ramp_next = '0;
		end else begin
			ramp_next = ramp_q - cfg.down_step;
		end
	end

	assign ramp_s = signed'({1'b0, ramp_next});

	// left beats right, up beats down
	always_comb begin
		if (in_data.dir_left)
			horiz = -ramp_s;
		else if (in_data.dir_right)
			horiz = ramp_s;
		else
			horiz = '0;
		if (in_data.dir_up)
			vert = -ramp_s;
		else if (in_data.dir_down)
			vert = ramp_s;
		else
			vert = '0;
	end

	assign emits = (buttons != prev_buttons_q) || (dirs != prev_dirs_q) || held;

	always_comb begin
		batch.chg     = buttons ^ prev_buttons_q;
		batch.buttons = buttons;
		batch.send_h  = !sent_once_q || (horiz != last_h_q);
		batch.h_val   = horiz;
		batch.send_v  = !sent_once_q || (vert != last_v_q);
		batch.v_val   = -vert;
	end

	// ramp moves on every sample; the rest only on samples that emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q <= '0;
			prev_dirs_q    <= '0;
			ramp_q         <= '0;
			last_h_q       <= '0;
			last_v_q       <= '0;
			sent_once_q    <= 1'b0;
		end else if (accept) begin
			ramp_q <= ramp_next;
			if (emits) begin
				prev_buttons_q <= buttons;
				prev_dirs_q    <= dirs;
				last_h_q       <= horiz;
				last_v_q       <= vert;
				sent_once_q    <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/gdpre_emit.sv =====
// Batch register and event sequencer: one event word per cycle into the output register
// while it is empty or out_ready is high. Uses gdpre_pkg and the assertion macros header.
`default_nettype none
`include "gamepad_dpad_ramp_event_encoder_top_defines.svh"

module gdpre_emit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire gdpre_pkg::batch_t batch,
	input  wire logic           load,
	input  wire logic           out_ready,
	output logic                take_ok,
	output logic                out_valid,
	output gdpre_pkg::out_t     out_data
);

	gdpre_pkg::batch_t batch_s1;
	logic              busy_s1;
	logic              out_valid_q;
	gdpre_pkg::out_t   out_q;

	logic                                adv;
	logic                                last_step;
	logic [gdpre_pkg::BtnIdxW-1:0]       btn_idx;
	logic [gdpre_pkg::NumButtons-1:0]    chg_rest;
	gdpre_pkg::out_t                     word;

	// lowest changed button
	always_comb begin
		btn_idx = '0;
		for (int i = gdpre_pkg::NumButtons - 1; i >= 0; i--) begin
			if (batch_s1.chg[i])
				btn_idx = gdpre_pkg::BtnIdxW'(i);
		end
	end

	assign chg_rest  = batch_s1.chg & (batch_s1.chg - {{(gdpre_pkg::NumButtons-1){1'b0}}, 1'b1});
	assign last_step = (batch_s1.chg == '0) && !batch_s1.send_h && !batch_s1.send_v;
	assign adv       = busy_s1 && (!out_valid_q || out_ready);
	// take a new sample once the send marker leaves
	assign take_ok   = !busy_s1 || (adv && last_step);

	always_comb begin
		word = '0;
		if (batch_s1.chg != '0) begin
			word.event_kind  = gdpre_pkg::KIND_BUTTON;
			word.event_index = 5'(btn_idx);
			word.event_value = {15'd0, batch_s1.buttons[btn_idx]};
		end else if (batch_s1.send_h) begin
			word.event_kind  = gdpre_pkg::KIND_AXIS;
			word.event_index = gdpre_pkg::AxisHoriz;
			word.event_value = batch_s1.h_val;
		end else if (batch_s1.send_v) begin
			word.event_kind  = gdpre_pkg::KIND_AXIS;
			word.event_index = gdpre_pkg::AxisVert;
			word.event_value = batch_s1.v_val;
		end else begin
			word.event_kind  = gdpre_pkg::KIND_MARK;
			word.is_last     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				busy_s1 <= 1'b1;
			else if (adv && last_step)
				busy_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// retire one pending event per advance
	always_ff @(posedge clk) begin
		if (load) begin
			batch_s1 <= batch;
		end else if (adv) begin
			if (batch_s1.chg != '0)
				batch_s1.chg <= chg_rest;
			else if (batch_s1.send_h)
				batch_s1.send_h <= 1'b0;
			else if (batch_s1.send_v)
				batch_s1.send_v <= 1'b0;
		end
		if (adv)
			out_q <= word;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`GDPRE_ASSERT_NXT(a_marker_ends_batch, adv && last_step,
		out_valid_q && out_q.is_last && out_q.event_kind == gdpre_pkg::KIND_MARK)
	`GDPRE_ASSERT_IMP(a_no_load_midbatch, busy_s1 && !(adv && last_step), !load)
	`GDPRE_ASSERT_NXT(a_button_first, adv && (batch_s1.chg != '0),
		out_q.event_kind == gdpre_pkg::KIND_BUTTON && !out_q.is_last)

endmodule

`default_nettype wire

// ===== hw/rtl/gamepad_dpad_ramp_event_encoder_top.sv =====
// Top level of the D-pad ramp event encoder.
// Instantiates gdpre_regs, gdpre_core and gdpre_emit; uses gdpre_pkg.
`default_nettype none

// One poll sample per input word; each sample updates the ramp and either produces
// nothing or a run of event words: one per changed button in rising index order, one
// per axis whose value changed (both on the first run), then a send marker with
// is_last set. A sample with k event words (k = changed buttons + changed axes + 1,
// at most 21) holds the sequencer until its marker enters the output register, which
// moves one word per cycle while out_ready is high; the next sample is taken in the
// same cycle. Ramp steps are written at byte address 0 (up) and 4 (down); the user
// must write them only while idle, as the block itself does not enforce it.

module gamepad_dpad_ramp_event_encoder_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire gdpre_pkg::in_t               in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output gdpre_pkg::out_t                   out_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [gdpre_pkg::AddrW-1:0]  paddr,
	input  wire logic [gdpre_pkg::DataW-1:0]  pwdata,
	output logic      [gdpre_pkg::DataW-1:0]  prdata,
	output logic                              pready
);

	gdpre_pkg::cfg_t   cfg;
	gdpre_pkg::batch_t batch;
	logic              emits;
	logic              accept;
	logic              take_ok;

	assign in_ready = take_ok;
	assign accept   = in_valid & take_ok;

	gdpre_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	gdpre_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (in_data),
		.accept  (accept),
		.cfg     (cfg),
		.batch   (batch),
		.emits   (emits)
	);

	gdpre_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.batch     (batch),
		.load      (accept & emits),
		.out_ready (out_ready),
		.take_ok   (take_ok),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== tb/sv/gdpre_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the D-pad ramp event encoder: follows the sample, event and register ports,
// predicts every event word and compares it with the word the block sends.
// Depends on gdpre_pkg for the word types, the event kinds and the register indexes.

module gdpre_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  gdpre_pkg::in_t                in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  gdpre_pkg::out_t               out_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gdpre_pkg::AddrW-1:0]   paddr,
	input  logic [gdpre_pkg::DataW-1:0]   pwdata,
	input  logic                          pready,
	output int                            errors,
	output int                            pending
);
	import gdpre_pkg::*;

	logic [RampW-1:0]      up_step;
	logic [RampW-1:0]      down_step;
	logic [NumButtons-1:0] last_btn;
	logic [3:0]            last_dir;
	logic [RampW-1:0]      ramp_lvl;
	logic signed [15:0]    sent_h;
	logic signed [15:0]    sent_v;
	logic                  axes_valid;
	out_t                  expected_events[$];

	function automatic out_t make_event(kind_t kind, logic [4:0] idx, logic signed [15:0] val,
			logic last);
		out_t ev;
		ev.event_kind  = kind;
		ev.event_index = idx;
		ev.event_value = val;
		ev.is_last     = last;
		return ev;
	endfunction

	// advance the ramp, then queue the batch this sample produces, if any
	function automatic void predict_events(in_t s);
		logic [3:0]         dirs;
		logic [15:0]        grown;
		logic signed [15:0] mag;
		logic signed [15:0] h;
		logic signed [15:0] v;
		dirs = {s.dir_down, s.dir_up, s.dir_right, s.dir_left};
		if (dirs != 4'd0) begin
			grown = {1'b0, ramp_lvl} + {1'b0, up_step};
			ramp_lvl = (grown > RampMax) ? RampW'(RampMax) : grown[RampW-1:0];
		end else if (down_step > ramp_lvl) begin
			ramp_lvl = '0;
		end else begin
			ramp_lvl = ramp_lvl - down_step;
		end

		// quiet tick: nothing changed and nothing held, so only the ramp moves
		if (s.button_bits == last_btn && dirs == last_dir && dirs == 4'd0)
			return;

		for (int i = 0; i < NumButtons; i++) begin
			if (s.button_bits[i] != last_btn[i])
				expected_events.push_back(make_event(KIND_BUTTON, 5'(i),
					s.button_bits[i] ? 16'sd1 : 16'sd0, 1'b0));
		end

		mag = $signed({1'b0, ramp_lvl});
		h = s.dir_left ? -mag : (s.dir_right ? mag : 16'sd0);
		v = s.dir_up ? -mag : (s.dir_down ? mag : 16'sd0);
		if (!axes_valid || h != sent_h)
			expected_events.push_back(make_event(KIND_AXIS, AxisHoriz, h, 1'b0));
		// vertical goes out negated
		if (!axes_valid || v != sent_v)
			expected_events.push_back(make_event(KIND_AXIS, AxisVert, -v, 1'b0));
		expected_events.push_back(make_event(KIND_MARK, 5'd0, 16'sd0, 1'b1));

		sent_h     = h;
		sent_v     = v;
		axes_valid = 1'b1;
		last_btn   = s.button_bits;
		last_dir   = dirs;
	endfunction

	function automatic void note_mismatch(string what, out_t want, out_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: expected kind %0d index %0d value %0d last %0d,",
				$realtime, what, want.event_kind, want.event_index, want.event_value,
				want.is_last, " got kind %0d index %0d value %0d last %0d",
				got.event_kind, got.event_index, got.event_value, got.is_last);
	endfunction

	function automatic void check_event(out_t got);
		out_t want;
		if (expected_events.size() == 0) begin
			note_mismatch("word with nothing expected", '0, got);
			return;
		end
		want = expected_events.pop_front();
		if (got.event_kind !== want.event_kind || got.event_index !== want.event_index ||
				got.event_value !== want.event_value || got.is_last !== want.is_last)
			note_mismatch("event word mismatch", want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_step    = UpStepReset;
			down_step  = DownStepReset;
			last_btn   = '0;
			last_dir   = '0;
			ramp_lvl   = '0;
			sent_h     = '0;
			sent_v     = '0;
			axes_valid = 1'b0;
			expected_events.delete();
			errors     = 0;
			pending    = 0;
		end else begin
			if (in_valid && in_ready)
				predict_events(in_data);
			if (out_valid && out_ready)
				check_event(out_data);
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == RegDownStep)
					down_step = pwdata[RampW-1:0];
				else
					up_step = pwdata[RampW-1:0];
			end
			pending = expected_events.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the D-pad ramp event encoder testbench: clock, reset, samples, register writes, stalls.
// Instantiates gamepad_dpad_ramp_event_encoder_top and gdpre_checker; uses gdpre_pkg.

module tb_top;
	import gdpre_pkg::*;

	localparam int CycleLimit = 400000;
	localparam logic [AddrW-1:0] AddrUpStep   = {RegUpStep, 2'b00};
	localparam logic [AddrW-1:0] AddrDownStep = {RegDownStep, 2'b00};
	localparam logic [3:0] DirNone = 4'b0000;
	localparam logic [3:0] DirL    = 4'b0001;
	localparam logic [3:0] DirR    = 4'b0010;
	localparam logic [3:0] DirU    = 4'b0100;
	localparam logic [3:0] DirD    = 4'b1000;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_t              in_data;
	logic             out_valid;
	logic             out_ready;
	out_t             out_data;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;

	int errors;
	int pending;
	int burst_left;
	int cycles;
	int dir_run;
	logic                  hold_req;
	logic [NumButtons-1:0] cur_btn;
	logic [3:0]            cur_dir;

	gamepad_dpad_ramp_event_encoder_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	gdpre_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pready   (pready),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic in_t make_sample(logic [NumButtons-1:0] buttons, logic [3:0] dirs);
		in_t s;
		s.button_bits = buttons;
		s.dir_left    = dirs[0];
		s.dir_right   = dirs[1];
		s.dir_up      = dirs[2];
		s.dir_down    = dirs[3];
		return s;
	endfunction

	// offer one sample word in bursts; hold valid high until it is taken
	task automatic send_sample(input in_t s);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
			burst_left = $urandom_range(1, 10);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= s;
		do @(posedge clk); while (!in_ready);
	endtask

	// drop valid, drain every expected word, then let the sequencer run out
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [AddrW-1:0] addr, input logic [RampW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= DataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_random(input int n);
		int r;
		logic [NumButtons-1:0] flips;
		repeat (n) begin
			// hold a direction pattern for a run of ticks so the ramp can build up
			if (dir_run == 0) begin
				cur_dir = ($urandom_range(0, 4) == 0) ? DirNone : 4'($urandom_range(1, 15));
				dir_run = $urandom_range(1, 12);
			end
			dir_run--;
			r = $urandom_range(0, 9);
			if (r < 5)
				flips = NumButtons'(1) << $urandom_range(0, NumButtons - 1);
			else if (r < 7)
				flips = NumButtons'($urandom) & NumButtons'($urandom);
			else if (r == 7)
				flips = NumButtons'($urandom);
			else
				flips = '0;
			cur_btn = cur_btn ^ flips;
			send_sample(make_sample(cur_btn, cur_dir));
		end
	endtask

	// receiver: stall patterns of random length, plus one long hold-off on request
	initial begin : rx_pattern
		int mode;
		int len;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(5, 60);
			repeat (len) begin
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 7) != 0);
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : stimulus
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		hold_req   = 1'b0;
		burst_left = 0;
		dir_run    = 0;
		cur_btn    = '0;
		cur_dir    = DirNone;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset steps: quiet first tick, first batch, opposing directions, button patterns
		send_sample(make_sample('0, DirNone));
		send_sample(make_sample('1, DirNone));
		send_sample(make_sample('1, DirNone));
		send_sample(make_sample('1, DirL));
		send_sample(make_sample('1, DirL | DirR));
		send_sample(make_sample('1, DirR));
		send_sample(make_sample(18'h2AAAA, DirU | DirD));
		send_sample(make_sample(18'h15555, DirD));
		send_sample(make_sample(18'h15555, DirD));
		send_sample(make_sample('0, DirNone));
		send_sample(make_sample('0, DirNone));
		send_sample(make_sample(18'h00001, DirNone));
		send_sample(make_sample(18'h20000, DirNone));
		settle();

		// full growth, no decay: saturate at the top and stay there
		write_reg(AddrUpStep, 15'h7FFF);
		write_reg(AddrDownStep, 15'h0000);
		send_sample(make_sample(18'h20000, DirL | DirU));
		send_sample(make_sample(18'h20000, DirL | DirU));
		send_sample(make_sample(18'h20000, DirNone));
		send_sample(make_sample(18'h20000, DirR | DirD));
		settle();

		// no growth, full decay: held direction with an unchanged zero axis
		write_reg(AddrUpStep, 15'h0000);
		write_reg(AddrDownStep, 15'h7FFF);
		send_sample(make_sample(18'h20000, DirNone));
		send_sample(make_sample(18'h20000, DirR));
		send_sample(make_sample(18'h20000, DirR));
		send_sample(make_sample('0, DirNone));
		settle();
		cur_btn = '0;

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(AddrUpStep, 15'h7FFF);
					write_reg(AddrDownStep, 15'h7FFF);
				end
				1: begin
					write_reg(AddrUpStep, 15'($urandom_range(1, 4000)));
					write_reg(AddrDownStep, 15'($urandom_range(1, 4000)));
					hold_req = 1'b1;
				end
				2: begin
					write_reg(AddrUpStep, 15'h0000);
					write_reg(AddrDownStep, 15'h0000);
				end
				default: begin
					write_reg(AddrUpStep, 15'($urandom_range(0, 32767)));
					write_reg(AddrDownStep, 15'($urandom_range(0, 32767)));
				end
			endcase
			run_random(40);
			settle();
		end

		if (errors == 0 && pending == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
